// ----- design/tlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlfq_pkg: shared types and constants of the feedback queue scheduler
// Holds event kinds, task phases, register indexes and payload structs.
// ----------------------------------------------------------------------------
package tlfq_pkg;

  localparam int DefSlots  = 16;
  localparam int DefIdBits = 8;
  localparam int TaskW     = 8;
  localparam int QW        = 3;
  localparam int StampW    = 16;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_PASS   = 2'd1;
  localparam logic [1:0] KIND_IO     = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [1:0] PH_NEW   = 2'd0;
  localparam logic [1:0] PH_READY = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_WAIT  = 2'd3;

  localparam logic [1:0] REG_Q1   = 2'd0;
  localparam logic [1:0] REG_Q2   = 2'd1;
  localparam logic [1:0] REG_Q3   = 2'd2;
  localparam logic [1:0] REG_WAIT = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TaskW-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic             running_valid;
    logic [TaskW-1:0] running_id;
    logic [1:0]       active_level;
    logic             time_advanced;
    logic             all_done;
    logic             table_full;
  } out_item_t;

  // Scan commands from controller to datapath
  typedef struct packed {
    logic       scan_clr;   // restart scan accumulators
    logic       scan_step;  // look at one slot
    logic       apply;      // commit the event
    logic       tick;       // one aging step over one slot
  } dp_cmd_t;

  typedef struct packed {
    logic last_slot;        // scan pointer at final slot
  } dp_sts_t;

endpackage

// ----- design/tlfq_datapath.sv -----
// ----------------------------------------------------------------------------
// tlfq_datapath: slot table, scan accumulators and event commit
// Scans the table one slot per cycle, applies the event, then ages waiting tasks.
// ----------------------------------------------------------------------------
module tlfq_datapath import tlfq_pkg::*; #(
  parameter int SLOTS   = DefSlots,
  parameter int ID_BITS = DefIdBits
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_item_t        item,
  input  dp_cmd_t         cmd,
  output dp_sts_t         sts,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [QW-1:0]   cfg_data,
  output out_item_t       result
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0]        used_r;
  logic [ID_BITS-1:0]      task_r  [SLOTS];
  logic [1:0]              lvl_r   [SLOTS];
  logic [1:0]              ph_r    [SLOTS];
  logic [QW-1:0]           wcnt_r  [SLOTS];
  logic [SLOTS-1:0]        moved_r;
  logic [StampW-1:0]       stamp_r [SLOTS];

  logic [StampW-1:0]       next_stamp_r;
  logic [1:0]              lis_r;
  logic                    cur_v_r;
  logic [SW-1:0]           cur_s_r;
  logic                    fresh_r;
  logic [QW-1:0]           qu_r [3];
  logic                    last_t_r;
  logic [QW-1:0]           cq_r [3];
  logic [QW-1:0]           wt_r;

  // scan state
  logic [SW-1:0]           ptr_r;
  logic [2:0]              rdy_r;      // level 1..3 has a ready task
  logic [2:0]              rdy_cnt2_r; // second ready task seen per level
  logic                    wait_r;
  logic                    free_v_r;
  logic [SW-1:0]           free_s_r;
  logic [2:0]              best_v_r;
  logic [SW-1:0]           best_s_r [3];
  logic [StampW-1:0]       best_a_r [3];
  logic                    adv_r;      // time advance decided at apply
  out_item_t               res_r;

  assign sts.last_slot = (ptr_r == SW'(SLOTS-1));
  assign result = res_r;

  logic                    p_rdy;
  logic [StampW-1:0]       p_age;
  assign p_rdy = used_r[ptr_r] && (ph_r[ptr_r] == PH_NEW || ph_r[ptr_r] == PH_READY);
  assign p_age = next_stamp_r - stamp_r[ptr_r];

  // Event decision, evaluated from scan results
  logic [1:0]  sel_lvl;
  logic [1:0]  qi;
  logic        expire;
  always_comb begin
    sel_lvl = 2'd0;
    if ((lis_r == 2'd0 && rdy_r[0]) || lis_r == 2'd1) sel_lvl = 2'd1;
    else if ((lis_r == 2'd0 && rdy_r[1]) || lis_r == 2'd2) sel_lvl = 2'd2;
    else if ((lis_r == 2'd0 && rdy_r[2]) || lis_r == 2'd3) sel_lvl = 2'd3;
    qi = (sel_lvl == 2'd0) ? 2'd0 : sel_lvl - 2'd1;
    expire = (sel_lvl != 2'd0) && (qu_r[qi] == cq_r[qi]);
  end

  // Result of a pass for ready-any test after the serve step
  logic        pick_ok;
  logic        ready_after;
  always_comb begin
    pick_ok = (sel_lvl != 2'd0) && !expire && !cur_v_r && best_v_r[qi];
    // readiness after serve: picked task leaves ready, expired task becomes ready
    ready_after = 1'b0;
    if (rdy_r != 3'b000) ready_after = 1'b1;
    if (pick_ok) begin
      ready_after = 1'b0;
      for (int l = 0; l < 3; l++) begin
        if (rdy_r[l] && !(l == int'(qi))) ready_after = 1'b1;
      end
      // another ready task at same level
      if (best_v_r[qi] && rdy_cnt2_r[qi]) ready_after = 1'b1;
    end
    if (expire && cur_v_r) ready_after = 1'b1;
  end

  // Decide whether a pass advances time
  logic        pass_adv;
  always_comb begin
    pass_adv = last_t_r;
    if (sel_lvl != 2'd0) pass_adv = !expire;
    if (!ready_after && wait_r) pass_adv = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      next_stamp_r <= '0;
      lis_r        <= '0;
      cur_v_r      <= 1'b0;
      cur_s_r      <= '0;
      fresh_r      <= 1'b0;
      last_t_r     <= 1'b0;
      for (int i = 0; i < 3; i++) qu_r[i] <= '0;
      cq_r[0]      <= QW'(1);
      cq_r[1]      <= QW'(2);
      cq_r[2]      <= QW'(4);
      wt_r         <= QW'(3);
      ptr_r        <= '0;
      adv_r        <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_Q1:   cq_r[0] <= cfg_data;
          REG_Q2:   cq_r[1] <= cfg_data;
          REG_Q3:   cq_r[2] <= cfg_data;
          REG_WAIT: wt_r    <= cfg_data;
          default:  ;
        endcase
      end
      // clear the scan accumulators
      if (cmd.scan_clr) begin
        ptr_r    <= '0;
        rdy_r    <= '0;
        rdy_cnt2_r <= '0;
        wait_r   <= 1'b0;
        free_v_r <= 1'b0;
        best_v_r <= '0;
      end
      // examine one slot
      if (cmd.scan_step) begin
        ptr_r <= ptr_r + SW'(1);
        if (!used_r[ptr_r] && !free_v_r) begin
          free_v_r <= 1'b1;
          free_s_r <= ptr_r;
        end
        if (used_r[ptr_r] && ph_r[ptr_r] == PH_WAIT) wait_r <= 1'b1;
        for (int l = 0; l < 3; l++) begin
          if (p_rdy && lvl_r[ptr_r] == 2'(l + 1)) begin
            if (rdy_r[l]) rdy_cnt2_r[l] <= 1'b1;
            rdy_r[l] <= 1'b1;
            if (!best_v_r[l] || p_age > best_a_r[l]) begin
              best_v_r[l] <= 1'b1;
              best_s_r[l] <= ptr_r;
              best_a_r[l] <= p_age;
            end
          end
        end
      end
      // commit the event
      if (cmd.apply) begin
        ptr_r <= '0;
        res_r.time_advanced <= (item.kind == KIND_PASS) && pass_adv;
        res_r.table_full    <= (item.kind == KIND_ADD) && !free_v_r;
        adv_r               <= (item.kind == KIND_PASS) && pass_adv;
        case (item.kind)
          KIND_ADD: begin
            if (free_v_r) begin
              used_r[free_s_r]   <= 1'b1;
              task_r[free_s_r]   <= item.task_id[ID_BITS-1:0];
              lvl_r[free_s_r]    <= 2'd1;
              ph_r[free_s_r]     <= PH_NEW;
              wcnt_r[free_s_r]   <= '0;
              moved_r[free_s_r]  <= 1'b0;
              stamp_r[free_s_r]  <= next_stamp_r;
              next_stamp_r       <= next_stamp_r + StampW'(1);
            end
          end
          KIND_PASS: begin
            if (sel_lvl != 2'd0) begin
              if (expire) begin
                if (cur_v_r) begin
                  if (sel_lvl != 2'd3) begin
                    lvl_r[cur_s_r]   <= sel_lvl + 2'd1;
                    stamp_r[cur_s_r] <= next_stamp_r;
                    next_stamp_r     <= next_stamp_r + StampW'(1);
                  end
                  ph_r[cur_s_r]    <= PH_READY;
                  moved_r[cur_s_r] <= 1'b1;
                end
                cur_v_r    <= 1'b0;
                qu_r[qi]   <= '0;
                lis_r      <= 2'd0;
              end else begin
                lis_r <= sel_lvl;
                if (!cur_v_r) begin
                  if (best_v_r[qi]) begin
                    cur_v_r <= 1'b1;
                    cur_s_r <= best_s_r[qi];
                    ph_r[best_s_r[qi]] <= PH_RUN;
                    fresh_r <= 1'b0;
                  end else begin
                    fresh_r <= 1'b1;
                  end
                end else begin
                  moved_r[cur_s_r] <= 1'b0;
                  if (fresh_r) begin
                    fresh_r <= 1'b0;
                    ph_r[cur_s_r] <= PH_RUN;
                  end
                end
                qu_r[qi] <= qu_r[qi] + QW'(1);
              end
            end
            last_t_r <= pass_adv;
          end
          KIND_IO: begin
            if (cur_v_r) begin
              ph_r[cur_s_r]   <= PH_WAIT;
              wcnt_r[cur_s_r] <= '0;
              if (!moved_r[cur_s_r] && (lis_r == 2'd2 || lis_r == 2'd3)) begin
                lvl_r[cur_s_r]   <= lis_r - 2'd1;
                stamp_r[cur_s_r] <= next_stamp_r;
                next_stamp_r     <= next_stamp_r + StampW'(1);
              end
            end
            cur_v_r <= 1'b0;
          end
          default: begin
            if (cur_v_r) begin
              used_r[cur_s_r] <= 1'b0;
              cur_v_r         <= 1'b0;
              lis_r           <= 2'd0;
            end
          end
        endcase
      end
      // age waiting tasks one slot a cycle
      if (cmd.tick) begin
        ptr_r <= ptr_r + SW'(1);
        if (adv_r && used_r[ptr_r] && ph_r[ptr_r] == PH_WAIT) begin
          if (wcnt_r[ptr_r] + QW'(1) == wt_r) begin
            ph_r[ptr_r]   <= PH_READY;
            wcnt_r[ptr_r] <= '0;
          end else begin
            wcnt_r[ptr_r] <= wcnt_r[ptr_r] + QW'(1);
          end
        end
        // capture result fields from committed state
        if (sts.last_slot) begin
          res_r.running_valid <= cur_v_r;
          res_r.running_id    <= cur_v_r ? TaskW'(task_r[cur_s_r]) : '0;
          res_r.active_level  <= lis_r;
          res_r.all_done      <= (used_r == '0);
        end
      end
    end
  end

endmodule

// ----- design/tlfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlfq_ctrl: event sequencer
// Accepts a transaction, runs scan, commit and aging sweeps, holds result.
// ----------------------------------------------------------------------------
module tlfq_ctrl import tlfq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    take,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign take      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.scan_clr = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.last_slot) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_TICK;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        if (sts.last_slot) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- design/three_level_feedback_queue_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler_unit: three-level feedback scheduler
// Task slot table with per-level quanta, IO waits and aging.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one event transaction (add, pass, IO, finish).
//   out_valid/out_ready return exactly one result transaction per event.
//   cfg_we/cfg_index/cfg_data write the three quanta and the IO wait count;
//   write only while the block is idle.
// Event sequence:
//   After an event is taken the block runs a scan sweep over the slot table,
//   a commit step and an aging sweep, each sweep visiting one slot per cycle,
//   and then raises out_valid. One event is in work at a time; the next is
//   taken the cycle after the result is delivered.
// Reset:
//   Synchronous active-low rst_n empties the table and loads default quanta
//   1, 2, 4 and IO wait 3.
// Stall:
//   While out_ready is low the result holds and no new event is taken.
// ----------------------------------------------------------------------------
module three_level_feedback_queue_scheduler_unit import tlfq_pkg::*; #(
  parameter int SLOTS   = DefSlots,
  parameter int ID_BITS = DefIdBits
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [QW-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     take;
  in_item_t item_r;

  // capture the event
  always_ff @(posedge clk) begin
    if (take) item_r <= in_data;
  end

  tlfq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .take, .cmd, .sts
  );

  tlfq_datapath #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_dp (
    .clk, .rst_n, .item(item_r), .cmd, .sts,
    .cfg_we, .cfg_index, .cfg_data, .result(out_data)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_step && cmd.tick)) else $error("scan and aging overlap");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_apply_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> !cmd.apply) else $error("double commit");

endmodule

// ----- sim/three_level_feedback_queue_scheduler_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler_unit_tb: scheduler testbench
// Drives add, pass, IO and finish events through the valid/ready channel,
// predicts every result with a local model of the slot table, queue levels,
// quanta and IO waits, and compares each result field by field.
// ----------------------------------------------------------------------------
module three_level_feedback_queue_scheduler_unit_tb;
  import tlfq_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 1500000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  in_item_t      in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  out_item_t     out_data;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [QW-1:0] cfg_data = '0;

  // scheduler model state
  logic             sl_used [NSLOT];
  logic [TaskW-1:0] sl_task [NSLOT];
  logic [1:0]       sl_level [NSLOT];
  logic [1:0]       sl_phase [NSLOT];
  logic [2:0]       sl_wait [NSLOT];
  logic             sl_moved [NSLOT];
  logic [15:0]      sl_stamp [NSLOT];
  logic [15:0]      stamp_ctr;
  logic [1:0]       serving;
  logic             run_valid;
  logic [3:0]       run_slot;
  logic             fresh;
  logic [2:0]       q_used [3];
  logic             last_adv;
  logic [2:0]       q_limit [3];
  logic [2:0]       wait_limit;

  out_item_t expected_results [$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        results_seen = 0;

  three_level_feedback_queue_scheduler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout waiting for scheduler results");
      $display("** three_level_feedback_queue_scheduler_unit: FAILED **");
      $finish;
    end
  end

  function automatic bit slot_ready(int s);
    return sl_used[s] && (sl_phase[s] == PH_NEW || sl_phase[s] == PH_READY);
  endfunction

  function automatic bit level_has_ready(logic [1:0] lvl);
    for (int s = 0; s < NSLOT; s++)
      if (slot_ready(s) && sl_level[s] == lvl) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit any_task_waiting();
    for (int s = 0; s < NSLOT; s++)
      if (sl_used[s] && sl_phase[s] == PH_WAIT) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int oldest_ready(logic [1:0] lvl);
    int best;
    logic [15:0] age, best_age;
    best = -1;
    best_age = '0;
    for (int s = 0; s < NSLOT; s++) begin
      if (!slot_ready(s) || sl_level[s] != lvl) continue;
      age = stamp_ctr - sl_stamp[s];
      if (best < 0 || age > best_age) begin
        best = s;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic void stamp(int s);
    sl_stamp[s] = stamp_ctr;
    stamp_ctr = stamp_ctr + 16'd1;
  endfunction

  task automatic reset_model();
    for (int s = 0; s < NSLOT; s++) begin
      sl_used[s] = 0; sl_task[s] = '0; sl_level[s] = '0; sl_phase[s] = PH_NEW;
      sl_wait[s] = '0; sl_moved[s] = 0; sl_stamp[s] = '0;
    end
    stamp_ctr = '0; serving = '0; run_valid = 0; run_slot = '0; fresh = 0;
    for (int i = 0; i < 3; i++) q_used[i] = '0;
    last_adv = 0;
    q_limit[0] = 3'd1; q_limit[1] = 3'd2; q_limit[2] = 3'd4;
    wait_limit = 3'd3;
  endtask

  // Serve one level for one pass; returns whether time advances
  function automatic bit serve(logic [1:0] lvl);
    int i, p;
    i = lvl - 1;
    if (q_used[i] == q_limit[i]) begin
      if (run_valid) begin
        if (lvl < 3) begin
          sl_level[run_slot] = lvl + 2'd1;
          stamp(run_slot);
        end
        sl_phase[run_slot] = PH_READY;
        sl_moved[run_slot] = 1;
      end
      run_valid = 0;
      q_used[i] = '0;
      serving = '0;
      return 1'b0;
    end
    serving = lvl;
    if (!run_valid) begin
      p = oldest_ready(lvl);
      fresh = 1;
      if (p >= 0) begin
        run_valid = 1;
        run_slot = p[3:0];
      end
    end else begin
      sl_moved[run_slot] = 0;
    end
    if (run_valid && fresh) begin
      fresh = 0;
      sl_phase[run_slot] = PH_RUN;
    end
    q_used[i] = q_used[i] + 3'd1;
    return 1'b1;
  endfunction

  // Predict the result of one event and queue it
  task automatic predict_event(in_item_t ev);
    out_item_t r;
    bit adv;
    logic [1:0] lv;
    r = '0;
    case (ev.kind)
      KIND_ADD: begin
        r.table_full = 1;
        for (int s = 0; s < NSLOT; s++) begin
          if (sl_used[s]) continue;
          sl_used[s] = 1; sl_task[s] = ev.task_id; sl_level[s] = 2'd1;
          sl_phase[s] = PH_NEW; sl_wait[s] = '0; sl_moved[s] = 0;
          stamp(s);
          r.table_full = 0;
          break;
        end
      end
      KIND_PASS: begin
        lv = serving;
        adv = last_adv;
        if ((lv == 0 && level_has_ready(2'd1)) || lv == 2'd1) adv = serve(2'd1);
        else if ((lv == 0 && level_has_ready(2'd2)) || lv == 2'd2) adv = serve(2'd2);
        else if ((lv == 0 && level_has_ready(2'd3)) || lv == 2'd3) adv = serve(2'd3);
        if (!(level_has_ready(2'd1) || level_has_ready(2'd2) || level_has_ready(2'd3))
            && any_task_waiting()) adv = 1;
        if (adv) begin
          for (int s = 0; s < NSLOT; s++) begin
            if (!sl_used[s] || sl_phase[s] != PH_WAIT) continue;
            sl_wait[s] = sl_wait[s] + 3'd1;
            if (sl_wait[s] == wait_limit) begin
              sl_phase[s] = PH_READY;
              sl_wait[s] = '0;
            end
          end
        end
        last_adv = adv;
        r.time_advanced = adv;
      end
      KIND_IO: begin
        if (run_valid) begin
          sl_phase[run_slot] = PH_WAIT;
          sl_wait[run_slot] = '0;
          if (!sl_moved[run_slot] && (serving == 2'd2 || serving == 2'd3)) begin
            sl_level[run_slot] = serving - 2'd1;
            stamp(run_slot);
          end
        end
        run_valid = 0;
      end
      default: begin
        if (run_valid) begin
          sl_used[run_slot] = 0;
          run_valid = 0;
          serving = '0;
        end
      end
    endcase
    r.all_done = 1;
    for (int s = 0; s < NSLOT; s++) if (sl_used[s]) r.all_done = 0;
    r.running_valid = run_valid;
    r.running_id = run_valid ? sl_task[run_slot] : '0;
    r.active_level = serving;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (out_data.running_valid !== e.running_valid)
          report_mismatch("running_valid", out_data.running_valid, e.running_valid);
        if (out_data.running_id !== e.running_id)
          report_mismatch("running_id", out_data.running_id, e.running_id);
        if (out_data.active_level !== e.active_level)
          report_mismatch("active_level", out_data.active_level, e.active_level);
        if (out_data.time_advanced !== e.time_advanced)
          report_mismatch("time_advanced", out_data.time_advanced, e.time_advanced);
        if (out_data.all_done !== e.all_done)
          report_mismatch("all_done", out_data.all_done, e.all_done);
        if (out_data.table_full !== e.table_full)
          report_mismatch("table_full", out_data.table_full, e.table_full);
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one event transaction
  task automatic send_event(logic [1:0] kind, logic [TaskW-1:0] id);
    in_item_t ev;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    ev.kind = kind;
    ev.task_id = id;
    in_data <= ev;
    in_valid <= 1'b1;
    predict_event(ev);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    // block is busy after a transaction; step past the drop
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_WAIT) wait_limit = val;
    else q_limit[idx] = val;
  endtask

  task automatic set_regs(logic [2:0] q1, logic [2:0] q2, logic [2:0] q3, logic [2:0] w);
    drain();
    write_reg(REG_Q1, q1);
    write_reg(REG_Q2, q2);
    write_reg(REG_Q3, q3);
    write_reg(REG_WAIT, w);
  endtask

  // Directed: empty table events, full table, id extremes, every kind
  task automatic test_directed();
    send_event(KIND_PASS, 8'h00);
    send_event(KIND_IO, 8'h00);
    send_event(KIND_FINISH, 8'h00);
    send_event(KIND_ADD, 8'h00);
    send_event(KIND_ADD, 8'hff);
    for (int i = 0; i < 15; i++) send_event(KIND_ADD, 8'h55 ^ i[7:0]);
    send_event(KIND_PASS, 8'hff);
    send_event(KIND_IO, 8'haa);
    send_event(KIND_PASS, 8'h00);
    send_event(KIND_FINISH, 8'h00);
    send_event(KIND_PASS, 8'h00);
  endtask

  // Random: mostly passes with some adds, IO and finishes
  task automatic test_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 18) send_event(KIND_ADD, 8'($urandom_range(255)));
      else if (r < 68) send_event(KIND_PASS, 8'($urandom_range(255)));
      else if (r < 84) send_event(KIND_IO, 8'($urandom_range(255)));
      else send_event(KIND_FINISH, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_idling(int count);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(count);
    send_idle_pct = 76;
    test_random(count);
    send_idle_pct = 0; recv_stall_pct = 76;
    test_random(count);
    send_idle_pct = 14; recv_stall_pct = 14;
    test_random(count);
    // hold off until every outstanding result has arrived
    while (expected_results.size() != 0) @(negedge clk);
    test_random(count);
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_config_sweep();
    set_regs(3'd7, 3'd7, 3'd7, 3'd7);
    test_random(150);
    set_regs(3'd1, 3'd1, 3'd1, 3'd1);
    test_random(150);
    set_regs(3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)),
             3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)));
    test_random(150);
    set_regs(3'd0, 3'd0, 3'd0, 3'd0);
    test_random(60);
    set_regs(3'd2, 3'd3, 3'd5, 3'd2);
    test_random(120);
  endtask

  initial begin
    reset_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_idling(140);
    test_config_sweep();
    drain();
    if (error_count == 0) begin
      $display("** three_level_feedback_queue_scheduler_unit: PASSED **");
    end else begin
      $display("** three_level_feedback_queue_scheduler_unit: FAILED **");
    end
    $finish;
  end

endmodule
